// File: rtl/stg_pkg.sv
// Shared constants, types and state codes for the star-transposition swap generator.
`default_nettype none

package stg_pkg;

  // Largest permutation size handled
  localparam int MAX_ELEMENTS = 16;
  // One cell per level, levels 1 .. MAX_ELEMENTS-1
  localparam int NUM_CELLS    = MAX_ELEMENTS - 1;
  // Buffer entry / position / counter width
  localparam int IDX_W        = 4;
  // Size register and level width (holds MAX_ELEMENTS itself)
  localparam int SIZE_W       = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_ELEMENTS);

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } stg_state_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic              restart;  // treat counters as zero and buffer as identity
    logic              upd_en;   // commit this step
    logic              rev_en;   // reverse the prefix below lvl
    logic [SIZE_W-1:0] lvl;      // level advanced this step (size when none)
    logic [SIZE_W-1:0] size;     // active permutation size
  } stg_ctl_t;

endpackage

`default_nettype wire

// File: rtl/star_transposition_swap_gen.sv
// Top level: sequencer, row of level cells and result register.
//
//  channel | ports                                   | dir | carries
//  --------+-----------------------------------------+-----+---------------------------
//  in      | in_valid, in_ready, in_restart          | in  | request beat
//  out     | out_valid, out_ready, out_swap_position,| out | swap position / finished
//          | out_finished                            |     |
//  cfg     | cfg_valid, cfg_ready, cfg_perm_size     | in  | permutation size write
//
// On accept, the level found by the carry walk through the cell row is registered;
// in the update state the cells commit and the result register loads.
// The update waits while the result register is still full and out_ready is low.
// After reset: counters zero, buffer identity, size 4, no result pending.
// Configuration is always ready; the size is clamped to 2 .. 16.
`default_nettype none

module star_transposition_swap_gen (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_restart,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [stg_pkg::IDX_W-1:0]   out_swap_position,
  output logic                        out_finished,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [stg_pkg::SIZE_W-1:0]   cfg_perm_size
);
  import stg_pkg::*;

  stg_state_t        state_r, state_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] size_act;
  logic              restart_r;
  logic              restart_sel;
  logic              done_r, done_nxt;
  logic              done_eff;
  logic [SIZE_W-1:0] lvl_r;
  logic [SIZE_W-1:0] lvl_f;
  logic              none_r;
  logic              go;
  logic              in_acc;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_pos_r;
  logic              out_fin_r;
  stg_ctl_t          ctl;

  logic [NUM_CELLS:0]   carry;
  logic [NUM_CELLS-1:0] hit;
  logic [IDX_W-1:0]     buf_eff [NUM_CELLS];
  logic [IDX_W-1:0]     buf_all [MAX_ELEMENTS];
  logic [IDX_W-1:0]     mirror  [NUM_CELLS];
  logic [IDX_W-1:0]     sel;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign go        = (state_r == ST_UPD) && (!out_valid_r || out_ready);

  // Size clamp
  always_comb begin
    if (size_r < SIZE_MIN) begin
      size_act = SIZE_MIN;
    end else if (size_r > SIZE_MAX) begin
      size_act = SIZE_MAX;
    end else begin
      size_act = size_r;
    end
  end

  assign restart_sel = (state_r == ST_UPD) ? restart_r : in_restart;
  assign done_eff    = done_r && !restart_sel;

  // Control to the cells
  always_comb begin
    ctl.restart = restart_sel;
    ctl.upd_en  = go && !done_eff;
    ctl.rev_en  = !none_r;
    ctl.lvl     = lvl_r;
    ctl.size    = size_act;
  end

  // Cell row, level k+1 in slot k
  assign carry[0] = 1'b1;
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    stg_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(k + 1)),
      .ctl        (ctl),
      .carry_in   (carry[k]),
      .mirror_val (mirror[k]),
      .carry_out  (carry[k+1]),
      .hit        (hit[k]),
      .buf_eff    (buf_eff[k])
    );
  end

  // Level found by the carry walk
  always_comb begin
    lvl_f = '0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      if (hit[k]) begin
        lvl_f = lvl_f | SIZE_W'(k + 1);
      end
    end
  end

  // Buffer view and mirrored prefix
  always_comb begin
    buf_all[0] = '0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      buf_all[k+1] = buf_eff[k];
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_mirror
    assign mirror[k] = buf_all[lvl_r[IDX_W-1:0] - IDX_W'(k + 1)];
  end

  assign sel = buf_all[lvl_r[IDX_W-1:0]];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign done_nxt = go ? (done_eff || none_r) : done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SIZE_RESET;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      if (cfg_valid && cfg_ready) size_r <= cfg_perm_size;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-item payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      restart_r <= in_restart;
      lvl_r     <= carry[NUM_CELLS] ? size_act : lvl_f;
      none_r    <= carry[NUM_CELLS];
    end
    if (go) begin
      out_fin_r <= done_eff || none_r;
      out_pos_r <= (done_eff || none_r) ? '0 : sel;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_swap_position = out_pos_r;
  assign out_finished      = out_fin_r;

  // Checks
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("more than one level selected");

  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) && !none_r |-> (lvl_r != '0) && (lvl_r < size_act))
    else $error("advanced level out of range");

  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_swap_position == '0)
    else $error("finished beat carries a swap position");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && !(go && restart_r) |=> done_r)
    else $error("done flag dropped without restart");

  a_acc_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_UPD) && !in_ready)
    else $error("accepted beat did not enter update");

endmodule

`default_nettype wire

// File: rtl/stg_cell.sv
// One level cell: mixed-radix counter digit plus one work buffer entry.
`default_nettype none

module stg_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire [stg_pkg::IDX_W-1:0]   cell_idx,    // tied to this cell's level
  input  wire stg_pkg::stg_ctl_t     ctl,
  input  wire                        carry_in,    // all lower levels full
  input  wire [stg_pkg::IDX_W-1:0]   mirror_val,  // buffer entry at lvl - cell_idx
  output logic                       carry_out,
  output logic                       hit,         // this cell is the level to advance
  output logic [stg_pkg::IDX_W-1:0]  buf_eff
);
  import stg_pkg::*;

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] buf_r, buf_nxt;
  logic [IDX_W-1:0] cnt_eff;
  logic             active;
  logic             full;
  logic             below_lvl;
  logic             at_lvl;

  // Values seen by this step, with restart folded in
  assign cnt_eff = ctl.restart ? '0 : cnt_r;
  assign buf_eff = ctl.restart ? cell_idx : buf_r;

  // Carry walk: a full level passes the carry on, levels at or past size pass it too
  assign active    = {1'b0, cell_idx} < ctl.size;
  assign full      = active && (cnt_eff >= cell_idx);
  assign carry_out = carry_in && (full || !active);
  assign hit       = carry_in && active && !full;

  assign below_lvl = {1'b0, cell_idx} < ctl.lvl;
  assign at_lvl    = {1'b0, cell_idx} == ctl.lvl;

  // Clear below the level, bump at the level, reverse the prefix
  always_comb begin
    cnt_nxt = cnt_r;
    buf_nxt = buf_r;
    if (ctl.upd_en) begin
      if (below_lvl) begin
        cnt_nxt = '0;
      end else if (at_lvl) begin
        cnt_nxt = cnt_eff + IDX_W'(1);
      end else begin
        cnt_nxt = cnt_eff;
      end
      buf_nxt = (ctl.rev_en && below_lvl) ? mirror_val : buf_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      buf_r <= cell_idx;
    end else begin
      cnt_r <= cnt_nxt;
      buf_r <= buf_nxt;
    end
  end

endmodule

`default_nettype wire

// File: verif/star_transposition_swap_gen_tb.sv
// Self-checking testbench for the star-transposition swap generator.
`default_nettype none

module star_transposition_swap_gen_tb;
  import stg_pkg::*;

  // One expected result beat
  typedef struct packed {
    logic [IDX_W-1:0] pos;
    logic             fin;
  } swap_res_t;

  // Directed row: optional size write before the beat, then one request beat.
  // Rows with a typed-in result carry it; the others are predicted.
  typedef struct packed {
    bit               wr_size;
    logic [SIZE_W-1:0] size;
    bit               restart;
    bit               known;
    logic [IDX_W-1:0] pos;
    bit               fin;
  } dir_row_t;

  localparam int NUM_DIR = 25;
  localparam int RAND_ITEMS = 1900;
  localparam int CALM_AFTER = 1650;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{1'b0, 5'd0,  1'b0, 1'b1, 4'd1, 1'b0},  // first swap after reset (size 4)
    '{1'b0, 5'd0,  1'b0, 1'b0, 4'd0, 1'b0},
    '{1'b0, 5'd0,  1'b0, 1'b0, 4'd0, 1'b0},
    '{1'b0, 5'd0,  1'b1, 1'b1, 4'd1, 1'b0},  // restart mid-run
    '{1'b1, 5'd2,  1'b1, 1'b1, 4'd1, 1'b0},  // smallest size
    '{1'b0, 5'd0,  1'b0, 1'b1, 4'd0, 1'b1},  // no level left
    '{1'b0, 5'd0,  1'b0, 1'b1, 4'd0, 1'b1},  // sticky after finishing
    '{1'b1, 5'd0,  1'b1, 1'b1, 4'd1, 1'b0},  // size 0 used as 2
    '{1'b0, 5'd0,  1'b0, 1'b1, 4'd0, 1'b1},
    '{1'b1, 5'd1,  1'b1, 1'b1, 4'd1, 1'b0},  // size 1 used as 2
    '{1'b0, 5'd0,  1'b0, 1'b1, 4'd0, 1'b1},
    '{1'b1, 5'd3,  1'b1, 1'b1, 4'd1, 1'b0},  // full size-3 run
    '{1'b0, 5'd0,  1'b0, 1'b0, 4'd0, 1'b0},
    '{1'b0, 5'd0,  1'b0, 1'b0, 4'd0, 1'b0},
    '{1'b0, 5'd0,  1'b0, 1'b0, 4'd0, 1'b0},
    '{1'b0, 5'd0,  1'b0, 1'b0, 4'd0, 1'b0},
    '{1'b0, 5'd0,  1'b0, 1'b1, 4'd0, 1'b1},  // six permutations visited
    '{1'b1, 5'd31, 1'b1, 1'b1, 4'd1, 1'b0},  // size 31 used as 16
    '{1'b0, 5'd0,  1'b0, 1'b0, 4'd0, 1'b0},
    '{1'b0, 5'd0,  1'b0, 1'b0, 4'd0, 1'b0},
    '{1'b1, 5'd16, 1'b0, 1'b0, 4'd0, 1'b0},  // largest size, no restart
    '{1'b1, 5'd5,  1'b0, 1'b0, 4'd0, 1'b0},  // shrink mid-run
    '{1'b0, 5'd0,  1'b0, 1'b0, 4'd0, 1'b0},
    '{1'b1, 5'd16, 1'b0, 1'b0, 4'd0, 1'b0},  // grow back, upper levels kept
    '{1'b0, 5'd0,  1'b1, 1'b1, 4'd1, 1'b0}
  };

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_swap_position;
  logic out_finished;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SIZE_W-1:0] cfg_perm_size = '0;

  // Typed-in expectation travelling with the request beat
  logic hint_known = 1'b0;
  logic [IDX_W-1:0] hint_pos = '0;
  logic hint_fin = 1'b0;

  // Predictor state
  logic [SIZE_W-1:0] lvl_cnt [0:MAX_ELEMENTS];
  logic [IDX_W-1:0] perm_buf [0:MAX_ELEMENTS-1];
  logic seq_done;
  logic [SIZE_W-1:0] size_reg;

  swap_res_t swap_expect_q [$];
  int errors = 0;
  int results_seen = 0;
  int finished_seen = 0;
  int size_writes = 0;
  int items_sent = 0;
  bit no_gaps = 1'b0;

  star_transposition_swap_gen dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_swap_position (out_swap_position),
    .out_finished      (out_finished),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_perm_size     (cfg_perm_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Counters to zero, buffer to identity, sequence live again
  function automatic void reload_perm();
    for (int i = 0; i <= MAX_ELEMENTS; i++) lvl_cnt[i] = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) perm_buf[i] = IDX_W'(i);
    seq_done = 1'b0;
  endfunction

  // One step of the swap sequence: carry walk, advance, output, prefix reversal
  function automatic swap_res_t next_swap(input logic restart);
    swap_res_t r;
    int n;
    int lvl;
    int lo;
    int hi;
    logic [IDX_W-1:0] t;
    n = (size_reg < SIZE_MIN) ? int'(SIZE_MIN) :
        (size_reg > SIZE_MAX) ? int'(SIZE_MAX) : int'(size_reg);
    r.pos = '0;
    r.fin = 1'b1;
    if (restart) reload_perm();
    if (seq_done) return r;
    lvl = 1;
    while (lvl < n && int'(lvl_cnt[lvl]) >= lvl) begin
      lvl_cnt[lvl] = '0;
      lvl++;
    end
    if (lvl >= n) begin
      seq_done = 1'b1;
      return r;
    end
    lvl_cnt[lvl] = lvl_cnt[lvl] + 1'b1;
    r.pos = perm_buf[lvl];
    r.fin = 1'b0;
    lo = 1;
    hi = lvl - 1;
    while (lo < hi) begin
      t = perm_buf[lo];
      perm_buf[lo] = perm_buf[hi];
      perm_buf[hi] = t;
      lo++;
      hi--;
    end
    return r;
  endfunction

  initial begin
    size_reg = SIZE_RESET;
    reload_perm();
  end

  // Scoreboard: result beats checked in order, request beats predicted
  always @(posedge clk) begin
    swap_res_t exp_r;
    swap_res_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_finished) finished_seen++;
        if (swap_expect_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, pos %0d finished %0b",
                   $time, out_swap_position, out_finished);
        end else begin
          exp_r = swap_expect_q.pop_front();
          if (out_swap_position !== exp_r.pos) begin
            errors++;
            $display("%0t: swap_position expected %0d got %0d",
                     $time, exp_r.pos, out_swap_position);
          end
          if (out_finished !== exp_r.fin) begin
            errors++;
            $display("%0t: finished expected %0b got %0b",
                     $time, exp_r.fin, out_finished);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_perm_size;
        size_writes++;
      end
      if (in_valid && in_ready) begin
        got = next_swap(in_restart);
        if (hint_known) begin
          got.pos = hint_pos;
          got.fin = hint_fin;
        end
        swap_expect_q.push_back(got);
      end
    end
  end

  // Result side backpressure
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!no_gaps && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Random sender gap
  task automatic maybe_gap();
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Drive one request beat and hold it until accepted
  task automatic send_req(input logic restart, input logic known,
                          input logic [IDX_W-1:0] pos, input logic fin);
    maybe_gap();
    in_valid   <= 1'b1;
    in_restart <= restart;
    hint_known <= known;
    hint_pos   <= pos;
    hint_fin   <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop sending until every expected result is back, then let the pipe settle.
  // It first waits for a clock edge so the beat accepted at the current edge is already queued.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (swap_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    drain();
    cfg_valid     <= 1'b1;
    cfg_perm_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int pick;
    int eff;
    int len;
    logic [SIZE_W-1:0] sz;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_ROWS[i].wr_size) write_size(DIR_ROWS[i].size);
      send_req(DIR_ROWS[i].restart, DIR_ROWS[i].known, DIR_ROWS[i].pos,
               DIR_ROWS[i].fin);
    end

    // random phases: mostly complete enumerations of small sizes
    while (items_sent < NUM_DIR + RAND_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) sz = SIZE_W'($urandom_range(2, 5));
      else if (pick < 16) sz = SIZE_W'($urandom_range(6, 16));
      else if (pick < 18) sz = SIZE_W'($urandom_range(0, 1));
      else sz = SIZE_W'($urandom_range(17, 31));
      eff = (sz < SIZE_MIN) ? int'(SIZE_MIN) :
            (sz > SIZE_MAX) ? int'(SIZE_MAX) : int'(sz);
      case (eff)
        2: len = 2;
        3: len = 6;
        4: len = 24;
        5: len = 120;
        default: len = $urandom_range(20, 90);
      endcase
      len += $urandom_range(0, 3);
      no_gaps = (items_sent >= CALM_AFTER) || ($urandom_range(0, 4) == 0);
      write_size(sz);
      for (int k = 0; k < len; k++) begin
        if (k == len / 2 && $urandom_range(0, 3) == 0) drain();
        if (k == 0) send_req($urandom_range(0, 3) != 0, 1'b0, '0, 1'b0);
        else send_req($urandom_range(0, 49) == 0, 1'b0, '0, 1'b0);
      end
    end

    // wind down
    in_valid <= 1'b0;
    @(posedge clk);
    while (swap_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Ran %0d request beats across %0d size writes, sizes 0 to 31 clamped to 2..16",
             items_sent, size_writes);
    $display("Checked %0d result beats, %0d of them end-of-sequence", results_seen,
             finished_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/stg_pkg.sv
rtl/stg_cell.sv
rtl/star_transposition_swap_gen.sv
verif/star_transposition_swap_gen_tb.sv
